>>> src/assert_macros.svh
// Assertion macros shared by the parser modules.
// Every macro checks on the rising clock edge and is switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/mfep_pkg.sv
// Shared constants and types of the MIDI file event parser.
// Used by the front parser, the record queue, the back serializer and the top level.
package mfep_pkg;

	localparam int MAX_VARLEN_DEF = 4;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int OUT_OFF_W = 32;
	localparam int DELTA_W = 28;
	localparam int TRACK_W = 16;
	localparam int WORD_W = 16;
	localparam int OUT_DATA_W = 136;
	localparam int KIND_W = 2;

	// Record kinds carried on the output tuser.
	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END_TRACK = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	// One queue entry holds every record caused by one input byte.
	typedef struct packed {
		logic hdr_v;
		logic ev_v;
		logic eot_v;
		logic [TRACK_W-1:0] track;
		logic [OUT_OFF_W-1:0] ev_off;
		logic [DELTA_W-1:0] delta;
		logic [7:0] status;
		logic err;
		logic [OUT_OFF_W-1:0] eot_off;
		logic [3*WORD_W-1:0] hdr_words;
	} entry_t;

endpackage

>>> src/mfep_front.sv
// Front part of the MIDI file event parser: takes one file byte per cycle unless
// the queue is full, frames chunks and events, pushes each byte's records. Uses mfep_pkg.
module mfep_front #(
	parameter int MAX_VARLEN_BYTES = mfep_pkg::MAX_VARLEN_DEF,
	parameter int OFFSET_BITS = mfep_pkg::OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	input logic in_sof,
	input logic q_full,
	output logic in_ready,
	output logic push,
	output mfep_pkg::entry_t push_entry
);

	localparam logic [3:0] PH_TYPE = 4'd0;
	localparam logic [3:0] PH_LEN = 4'd1;
	localparam logic [3:0] PH_HDR = 4'd2;
	localparam logic [3:0] PH_SKIPCHUNK = 4'd3;
	localparam logic [3:0] PH_DELTA = 4'd4;
	localparam logic [3:0] PH_STATUS = 4'd5;
	localparam logic [3:0] PH_METATYPE = 4'd6;
	localparam logic [3:0] PH_VLEN = 4'd7;
	localparam logic [3:0] PH_DATA = 4'd8;

	localparam logic [31:0] TAG_MTHD = 32'h4D54_6864;
	localparam logic [31:0] TAG_MTRK = 32'h4D54_726B;
	localparam int CNT_W = 4;
	localparam int DW = mfep_pkg::DELTA_W;
	localparam int OW = mfep_pkg::OUT_OFF_W;
	localparam int TW = mfep_pkg::TRACK_W;

	logic [3:0] phase_q;
	logic [31:0] type_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] chunk_left_q;
	logic [31:0] acc_q;
	logic [7:0] rs_q;
	logic [DW-1:0] skip_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [TW-1:0] track_q;
	logic [47:0] hdr_q;
	logic [OFFSET_BITS-1:0] ev_start_q;
	logic [DW-1:0] delta_q;
	logic err_q;
	logic active_q;

	logic [3:0] p;
	logic [31:0] ts;
	logic [CNT_W-1:0] cnt;
	logic [31:0] cl;
	logic [31:0] acc;
	logic [7:0] rs;
	logic [DW-1:0] skip;
	logic [OFFSET_BITS-1:0] pos;
	logic [TW-1:0] trk;
	logic [47:0] hdr;
	logic [OFFSET_BITS-1:0] es;
	logic [DW-1:0] dl;
	logic err;
	logic act;
	logic in_track;
	logic done;
	logic asb;
	logic [1:0] len;
	logic hdr_v;
	logic ev_v;
	logic eot_v;
	logic [TW-1:0] ev_track;
	logic [OW-1:0] ev_off;
	logic [DW-1:0] ev_delta;
	logic [7:0] ev_status;
	logic ev_err;
	logic [OW-1:0] eot_off;
	logic accept;

	assign in_ready = !q_full;
	assign accept = in_valid && !q_full;

	always_comb begin
		// A start-of-file byte is parsed from the reset state.
		p = in_sof ? PH_TYPE : phase_q;
		ts = in_sof ? '0 : type_q;
		cnt = in_sof ? '0 : cnt_q;
		cl = in_sof ? '0 : chunk_left_q;
		acc = in_sof ? '0 : acc_q;
		rs = in_sof ? '0 : rs_q;
		skip = in_sof ? '0 : skip_q;
		pos = in_sof ? '0 : pos_q;
		trk = in_sof ? '0 : track_q;
		hdr = in_sof ? '0 : hdr_q;
		es = in_sof ? '0 : ev_start_q;
		dl = in_sof ? '0 : delta_q;
		err = in_sof ? 1'b0 : err_q;
		act = in_sof ? 1'b0 : active_q;
		in_track = 1'b0;
		done = 1'b0;
		asb = 1'b0;
		len = 2'd0;
		hdr_v = 1'b0;
		ev_v = 1'b0;
		eot_v = 1'b0;
		ev_track = '0;
		ev_off = '0;
		ev_delta = '0;
		ev_status = '0;
		ev_err = 1'b0;
		eot_off = '0;

		case (p)
			PH_TYPE: begin
				if (cnt == '0) begin
					ts = '0;
				end
				ts = {ts[23:0], in_byte};
				cnt = cnt + 1'b1;
				if (cnt >= CNT_W'(4)) begin
					cnt = '0;
					acc = '0;
					p = PH_LEN;
				end
			end
			PH_LEN: begin
				acc = {acc[23:0], in_byte};
				cnt = cnt + 1'b1;
				if (cnt >= CNT_W'(4)) begin
					cl = acc;
					cnt = '0;
					acc = '0;
					if (ts == TAG_MTRK) begin
						rs = '0;
						act = 1'b0;
						if (cl == '0) begin
							eot_v = 1'b1;
							eot_off = OW'(pos);
							trk = trk + 1'b1;
							p = PH_TYPE;
						end else begin
							p = PH_DELTA;
						end
					end else if (cl == '0) begin
						p = PH_TYPE;
					end else if (ts == TAG_MTHD) begin
						hdr = '0;
						p = PH_HDR;
					end else begin
						p = PH_SKIPCHUNK;
					end
				end
			end
			default: begin
				in_track = (p >= PH_DELTA);
				if (p == PH_HDR) begin
					hdr = {hdr[39:0], in_byte};
					cnt = cnt + 1'b1;
					if (cnt >= CNT_W'(6)) begin
						hdr_v = 1'b1;
						cnt = '0;
						p = PH_SKIPCHUNK;
					end
				end else if (in_track) begin
					if (p == PH_DELTA) begin
						if (!act) begin
							act = 1'b1;
							es = pos;
							acc = '0;
							cnt = '0;
							err = 1'b0;
						end
						acc = {acc[24:0], in_byte[6:0]};
						cnt = cnt + 1'b1;
						done = !in_byte[7] || (cnt >= CNT_W'(MAX_VARLEN_BYTES));
						if (in_byte[7] && (cnt >= CNT_W'(MAX_VARLEN_BYTES))) begin
							err = 1'b1;
						end
						dl = acc[DW-1:0];
						if (done) begin
							p = PH_STATUS;
						end
					end else if (p == PH_STATUS) begin
						if (in_byte[7]) begin
							rs = in_byte;
						end
						case (rs[7:4]) inside
							[4'h8:4'hB], 4'hE: len = 2'd2;
							4'hC, 4'hD: len = 2'd1;
							default: len = 2'd0;
						endcase
						if (len != 2'd0) begin
							skip = DW'(len);
							p = PH_DATA;
						end else if (rs == 8'hFF) begin
							p = PH_METATYPE;
						end else begin
							p = PH_VLEN;
							acc = '0;
							cnt = '0;
						end
						// A data byte here is running status: it is also the first byte
						// of what follows the status.
						asb = !in_byte[7];
					end else begin
						asb = 1'b1;
					end

					if (asb) begin
						case (p)
							PH_METATYPE: begin
								p = PH_VLEN;
								acc = '0;
								cnt = '0;
							end
							PH_VLEN: begin
								acc = {acc[24:0], in_byte[6:0]};
								cnt = cnt + 1'b1;
								done = !in_byte[7] || (cnt >= CNT_W'(MAX_VARLEN_BYTES));
								if (in_byte[7] && (cnt >= CNT_W'(MAX_VARLEN_BYTES))) begin
									err = 1'b1;
								end
								if (done) begin
									skip = acc[DW-1:0];
									if (skip == '0) begin
										ev_v = 1'b1;
										ev_track = trk;
										ev_off = OW'(es);
										ev_delta = dl;
										ev_status = rs;
										ev_err = err;
										act = 1'b0;
										p = PH_DELTA;
									end else begin
										p = PH_DATA;
									end
								end
							end
							PH_DATA: begin
								skip = skip - 1'b1;
								if (skip == '0) begin
									ev_v = 1'b1;
									ev_track = trk;
									ev_off = OW'(es);
									ev_delta = dl;
									ev_status = rs;
									ev_err = err;
									act = 1'b0;
									p = PH_DELTA;
								end
							end
							default: begin
							end
						endcase
					end
				end

				cl = cl - 1'b1;
				if (cl == '0) begin
					if (in_track) begin
						// A chunk that ends inside an event still reports it.
						if (act) begin
							ev_v = 1'b1;
							ev_track = trk;
							ev_off = OW'(es);
							ev_delta = dl;
							ev_status = rs;
							ev_err = err;
						end
						eot_v = 1'b1;
						eot_off = OW'(pos);
						trk = trk + 1'b1;
					end
					act = 1'b0;
					cnt = '0;
					acc = '0;
					skip = '0;
					p = PH_TYPE;
				end
			end
		endcase
	end

	assign push = accept && (hdr_v || ev_v || eot_v);

	always_comb begin
		push_entry.hdr_v = hdr_v;
		push_entry.ev_v = ev_v;
		push_entry.eot_v = eot_v;
		push_entry.track = ev_v ? ev_track : (in_sof ? '0 : track_q);
		push_entry.ev_off = ev_off;
		push_entry.delta = ev_delta;
		push_entry.status = ev_status;
		push_entry.err = ev_err;
		push_entry.eot_off = eot_off;
		push_entry.hdr_words = hdr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q <= '0;
			cnt_q <= '0;
			chunk_left_q <= '0;
			acc_q <= '0;
			rs_q <= '0;
			skip_q <= '0;
			pos_q <= '0;
			track_q <= '0;
			hdr_q <= '0;
			ev_start_q <= '0;
			delta_q <= '0;
			err_q <= 1'b0;
			active_q <= 1'b0;
		end else if (accept) begin
			phase_q <= p;
			type_q <= ts;
			cnt_q <= cnt;
			chunk_left_q <= cl;
			acc_q <= acc;
			rs_q <= rs;
			skip_q <= skip;
			pos_q <= pos + 1'b1;
			track_q <= trk;
			hdr_q <= hdr;
			ev_start_q <= es;
			delta_q <= dl;
			err_q <= err;
			active_q <= act;
		end
	end

endmodule

>>> src/mfep_queue.sv
// Short record queue between the front parser and the back serializer.
// Holds mfep_pkg::entry_t items; the head is read straight from the storage registers.
`include "assert_macros.svh"

module mfep_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mfep_pkg::entry_t push_entry,
	input logic pop,
	output logic full,
	output logic head_v,
	output mfep_pkg::entry_t head
);

	localparam int DEPTH = mfep_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mfep_pkg::entry_t store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_v = (count_q != '0);
	assign head = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_v;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count above depth")
	`ASSERT_CLK(a_count_push, clk, arst_n, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1), "queue count missed a push")

endmodule

>>> src/mfep_back.sv
// Back part of the MIDI file event parser: turns queue entries into result items
// on the output stream through a registered output stage. Uses mfep_pkg.
`include "assert_macros.svh"

module mfep_back (
	input logic clk,
	input logic arst_n,
	input logic head_v,
	input mfep_pkg::entry_t head,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [mfep_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [mfep_pkg::KIND_W-1:0] m_tuser,
	output logic m_tlast
);

	localparam int DW = mfep_pkg::OUT_DATA_W;

	logic tvalid_q;
	logic [DW-1:0] tdata_q;
	logic [mfep_pkg::KIND_W-1:0] tuser_q;
	logic tlast_q;
	logic second_q;

	logic out_free;
	logic fire;
	logic first_of_two;
	logic emit_ev;
	logic pair_head;
	logic [mfep_pkg::KIND_W-1:0] kind;
	logic [DW-1:0] data;

	assign out_free = !tvalid_q || m_tready;
	assign fire = head_v && out_free;
	// An entry with both an event and an end of track gives the event first.
	assign first_of_two = head.ev_v && head.eot_v && !second_q;
	assign pop = fire && !first_of_two;
	assign emit_ev = head.ev_v && !second_q;
	assign pair_head = head_v && head.ev_v && head.eot_v;

	always_comb begin
		data = '0;
		if (head.hdr_v) begin
			kind = mfep_pkg::KIND_HEADER;
			data[99:84] = head.hdr_words[47:32];
			data[115:100] = head.hdr_words[31:16];
			data[131:116] = head.hdr_words[15:0];
			data[132] = head.hdr_words[15];
		end else if (emit_ev) begin
			kind = mfep_pkg::KIND_EVENT;
			data[15:0] = head.track;
			data[47:16] = head.ev_off;
			data[75:48] = head.delta;
			data[83:76] = head.status;
			data[133] = head.err;
		end else begin
			kind = mfep_pkg::KIND_END_TRACK;
			data[15:0] = head.track;
			data[47:16] = head.eot_off;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tdata_q <= data;
			tuser_q <= kind;
			tlast_q <= !first_of_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (fire) begin
				tvalid_q <= 1'b1;
				second_q <= first_of_two;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;
	assign m_tlast = tlast_q;

	`ASSERT_CLK(a_second_has_pair, clk, arst_n, second_q |-> pair_head, "lone pending end of track")
	`ASSERT_CLK(a_not_last_pending, clk, arst_n, (tvalid_q && !tlast_q) |-> second_q, "stray item")

endmodule

>>> src/midi_file_event_parser_unit.sv
// Path: a byte's records are pushed into the record queue, and the queue head is registered out.
// Throughput: one byte per cycle while the queue is not full; the output stage gives one item
// per cycle while not stalled, and a byte that causes an event and an end of track gives two, event first.
// A four-entry record queue lets the byte input keep running while the output stalls, until it is full.
// Reset (arst_n low) clears the parse state, the queue and the output stage at once;
// a byte with start_of_file set restarts the parse as file offset zero.
module midi_file_event_parser_unit #(
	parameter int MAX_VARLEN_BYTES = mfep_pkg::MAX_VARLEN_DEF,
	parameter int OFFSET_BITS = mfep_pkg::OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // byte_value
	input logic s_tuser, // start_of_file
	output logic m_tvalid,
	input logic m_tready,
	// track_index[15:0], event_offset[47:16], delta_time[75:48], event_status[83:76],
	// file_format[99:84], track_count[115:100], division_word[131:116],
	// uses_smpte[132], length_error[133], zero fill[135:134]
	output logic [mfep_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [mfep_pkg::KIND_W-1:0] m_tuser, // record_kind
	output logic m_tlast // last_of_run
);

	logic q_full;
	logic push;
	mfep_pkg::entry_t push_entry;
	logic pop;
	logic head_v;
	mfep_pkg::entry_t head;

	mfep_front #(
		.MAX_VARLEN_BYTES(MAX_VARLEN_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_byte(s_tdata),
		.in_sof(s_tuser),
		.q_full(q_full),
		.in_ready(s_tready),
		.push(push),
		.push_entry(push_entry)
	);

	mfep_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.full(q_full),
		.head_v(head_v),
		.head(head)
	);

	mfep_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_v(head_v),
		.head(head),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
